// ===== rtl/cse_pkg.sv =====
package cse_pkg;

    localparam int MaxRows = 1024;
    localparam int MaxCols = 8;
    localparam int RowW    = $clog2(MaxRows);
    localparam int ColW    = $clog2(MaxCols);
    localparam int AddrW   = RowW + ColW;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_SUM     = 3'd2,
        OP_PSUM    = 3'd3,
        OP_ALLSUM  = 3'd4,
        OP_PUPDATE = 3'd5,
        OP_RSVD6   = 3'd6,
        OP_RSVD7   = 3'd7
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_COLS  = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_EVAL,
        S_DONE
    } state_t;

endpackage

// ===== rtl/cse_ram.sv =====
module cse_ram #(
    parameter int AW = 13,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/column_store_scan_engine.sv =====
// Column-store scan engine.
// Requests arrive on the s_ channel (op, row_index, col_index, write_value,
// threshold_a, threshold_b) and each request yields exactly one result on the
// m_ channel (status, read_value, total, rows_updated).
// The table lives in one synchronous RAM of MaxRows * MaxCols words, column
// major. Row and column counts are set through the cfg_ port; the user must
// set them only while idle, as the block itself does not enforce this.
// A request is handled one field access at a time, each passing through
// address issue, RAM read, and evaluate or write back. A sum or predicated
// sum visits each row's needed columns; the all-columns sum reads every held
// column of each qualifying row, and the update reads columns 0, 2 and 3 and
// writes column 3 back. This follows from the single RAM port pair.
// One request is worked on at a time; s_ready is high only when idle.
// The result sits in an output register; while the receiver stalls it is
// held and no new request is taken.
// Reset clears the counts and the control state; the RAM is not cleared and
// its entries are undefined until written.
module column_store_scan_engine
    import cse_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_op,
    input  logic [9:0]         s_row_index,
    input  logic [2:0]         s_col_index,
    input  logic signed [31:0] s_write_value,
    input  logic signed [31:0] s_threshold_a,
    input  logic signed [31:0] s_threshold_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_read_value,
    output logic signed [63:0] m_total,
    output logic [10:0]        m_rows_updated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data
);

    state_t state_reg, state_next;

    logic [10:0] row_count_reg;
    logic [3:0]  col_count_reg;

    // Captured request.
    op_t                op_reg;
    logic [RowW-1:0]    rq_row_reg;
    logic [ColW-1:0]    rq_col_reg;
    logic [31:0]        wval_reg;
    logic signed [31:0] ta_reg, tb_reg;
    logic [10:0]        rows_reg;
    logic [3:0]         cols_reg;

    // Scan position: row, and step within the row.
    logic [10:0]        row_reg, row_next;
    logic [3:0]         step_reg, step_next;
    logic signed [31:0] c2_reg;

    logic [1:0]         status_reg;
    logic [31:0]        rval_reg;
    logic signed [63:0] total_reg, total_next;
    logic [10:0]        upd_reg, upd_next;

    logic [10:0] held_rows;
    logic [3:0]  held_cols;
    assign held_rows = (row_count_reg > 11'(MaxRows)) ? 11'(MaxRows) : row_count_reg;
    assign held_cols = (col_count_reg > 4'(MaxCols)) ? 4'(MaxCols) : col_count_reg;

    // RAM.
    logic               ram_we;
    logic [AddrW-1:0]   ram_waddr, ram_raddr;
    logic [31:0]        ram_wdata, ram_rdata;
    logic signed [31:0] rd;
    assign rd = ram_rdata;

    cse_ram #(.AW(AddrW), .DW(32)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic s_fire;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = (state_reg == S_DONE);

    // Column read at the current step, per op.
    logic [ColW-1:0] step_col;
    always_comb begin
        step_col = step_reg[ColW-1:0];
        case (op_reg)
            OP_READ, OP_WRITE: step_col = rq_col_reg;
            OP_SUM:            step_col = '0;
            OP_PSUM: begin
                // Columns 1, 2 then 0.
                case (step_reg)
                    4'd0:    step_col = ColW'(1);
                    4'd1:    step_col = ColW'(2);
                    default: step_col = '0;
                endcase
            end
            OP_PUPDATE: begin
                // Columns 0, 2 then 3.
                case (step_reg)
                    4'd0:    step_col = '0;
                    4'd1:    step_col = ColW'(2);
                    default: step_col = ColW'(3);
                endcase
            end
            default: step_col = step_reg[ColW-1:0];
        endcase
    end

    logic [RowW-1:0] scan_row;
    assign scan_row = (op_reg == OP_READ || op_reg == OP_WRITE) ? rq_row_reg
                                                                : row_reg[RowW-1:0];
    assign ram_raddr = {step_col, scan_row};

    // Status of the captured request, decided at capture.
    logic [1:0] st_in;
    logic       direct_done;
    always_comb begin
        st_in       = ST_OK;
        direct_done = 1'b0;
        case (op_t'(s_op))
            OP_READ, OP_WRITE: begin
                if ({1'b0, s_row_index} >= held_rows || {1'b0, s_col_index} >= held_cols) begin
                    st_in       = ST_RANGE;
                    direct_done = 1'b1;
                end
            end
            OP_SUM, OP_ALLSUM: begin
                if (held_cols < 4'd1) begin
                    st_in = ST_COLS; direct_done = 1'b1;
                end
            end
            OP_PSUM: begin
                if (held_cols < 4'd3) begin
                    st_in = ST_COLS; direct_done = 1'b1;
                end
            end
            OP_PUPDATE: begin
                if (held_cols < 4'd4) begin
                    st_in = ST_COLS; direct_done = 1'b1;
                end
            end
            default: direct_done = 1'b1;
        endcase
        if (!direct_done && s_op >= OP_SUM && held_rows == 11'd0) begin
            direct_done = 1'b1;
        end
    end

    // Evaluate step: decide what follows a RAM read.
    logic last_step;
    logic row_end;
    logic last_row;
    assign last_row = (row_reg + 11'd1 >= rows_reg);

    always_comb begin
        total_next = total_reg;
        upd_next   = upd_reg;
        step_next  = step_reg + 4'd1;
        row_end    = 1'b0;
        last_step  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = {step_col, scan_row};
        ram_wdata  = wval_reg;
        case (op_reg)
            OP_READ: last_step = 1'b1;
            OP_WRITE: begin
                ram_we    = (state_reg == S_EVAL);
                last_step = 1'b1;
            end
            OP_SUM: begin
                total_next = total_reg + 64'(rd);
                row_end    = 1'b1;
            end
            OP_PSUM: begin
                case (step_reg)
                    4'd0: begin
                        if (!(rd > ta_reg)) row_end = 1'b1;
                    end
                    4'd1: begin
                        if (!(rd < tb_reg)) row_end = 1'b1;
                    end
                    default: begin
                        total_next = total_reg + 64'(rd);
                        row_end    = 1'b1;
                    end
                endcase
            end
            OP_ALLSUM: begin
                if (step_reg == 4'd0 && !(rd > ta_reg)) begin
                    row_end = 1'b1;
                end else begin
                    total_next = total_reg + 64'(rd);
                    if (step_reg + 4'd1 >= cols_reg) row_end = 1'b1;
                end
            end
            OP_PUPDATE: begin
                case (step_reg)
                    4'd0: if (!(rd < ta_reg)) row_end = 1'b1;
                    4'd1: ;
                    default: begin
                        ram_we    = (state_reg == S_EVAL);
                        ram_wdata = c2_reg + rd;
                        upd_next  = upd_reg + 11'd1;
                        row_end   = 1'b1;
                    end
                endcase
            end
            default: last_step = 1'b1;
        endcase
        if (row_end) begin
            step_next = '0;
            last_step = last_row;
        end
        if (state_reg != S_EVAL) begin
            ram_we = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_fire) state_next = direct_done ? S_DONE : S_ISSUE;
            S_ISSUE: state_next = S_WAIT;
            S_WAIT:  state_next = S_EVAL;
            S_EVAL:  state_next = last_step ? S_DONE : S_ISSUE;
            S_DONE:  if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        row_next = row_reg;
        if (state_reg == S_EVAL && row_end) begin
            row_next = row_reg + 11'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            row_count_reg <= '0;
            col_count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ROWS) row_count_reg <= cfg_data[10:0];
                else                       col_count_reg <= cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg     <= op_t'(s_op);
            rq_row_reg <= s_row_index;
            rq_col_reg <= s_col_index;
            wval_reg   <= s_write_value;
            ta_reg     <= s_threshold_a;
            tb_reg     <= s_threshold_b;
            rows_reg   <= held_rows;
            cols_reg   <= held_cols;
            row_reg    <= '0;
            step_reg   <= '0;
            status_reg <= st_in;
            rval_reg   <= (st_in == ST_RANGE && s_op == OP_READ) ? 32'hFFFF_FFFF : 32'd0;
            total_reg  <= '0;
            upd_reg    <= '0;
        end else if (state_reg == S_EVAL) begin
            row_reg   <= row_next;
            step_reg  <= step_next;
            total_reg <= total_next;
            upd_reg   <= upd_next;
            if (op_reg == OP_PUPDATE && step_reg == 4'd1) c2_reg <= rd;
            if (op_reg == OP_READ) rval_reg <= rd;
        end
    end

    assign m_status       = status_reg;
    assign m_read_value   = rval_reg;
    assign m_total        = total_reg;
    assign m_rows_updated = upd_reg;

endmodule
